// ===== hw/rtl/dsd_pkg.sv =====
// Shared types, constants and helpers for the disk seek distance block.
// No dependencies; used by dsd_cell and disk_seek_distance_top.
package dsd_pkg;

    localparam int MAX_REQ = 64;
    localparam int IDX_W   = $clog2(MAX_REQ);
    localparam int CNT_W   = IDX_W + 1;
    localparam int CYL_W   = 16;
    localparam int DIST_W  = 22;
    localparam int STEP_W  = 18;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    localparam logic [1:0] MODE_SSTF  = 2'd1;
    localparam logic [1:0] MODE_CSCAN = 2'd2;

    localparam logic REG_POLICY = 1'b0;
    localparam logic REG_TOP    = 1'b1;

    typedef struct packed {
        logic [CYL_W-1:0] request_cylinder;
        logic             last_request;
    } in_item_t;

    typedef struct packed {
        logic [DIST_W-1:0] total_distance;
        logic              overflow_flag;
    } out_item_t;

    typedef struct packed {
        logic [CYL_W-1:0] cyl;
        logic             served;
    } cell_t;

    typedef struct packed {
        logic clear;
        logic shift;
    } cell_ctl_t;

    function automatic logic [CYL_W-1:0] clamp(input logic [CYL_W-1:0] c,
                                               input logic [CYL_W-1:0] top);
        clamp = (c > top) ? top : c;
    endfunction

    function automatic logic [CYL_W-1:0] gap(input logic [CYL_W-1:0] a,
                                             input logic [CYL_W-1:0] b);
        gap = (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

// ===== hw/rtl/dsd_cell.sv =====
// One cell of the request ring: a stored cylinder and its served flag.
// Depends on dsd_pkg.
module dsd_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dsd_pkg::cell_ctl_t    ctl,
    input  logic                  load_en,
    input  logic [15:0]           load_cyl,
    input  logic                  mark_en,
    input  dsd_pkg::cell_t        from_next,
    output dsd_pkg::cell_t        value
);
    import dsd_pkg::*;

    logic [CYL_W-1:0] cyl_reg;
    logic             served_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            cyl_reg <= from_next.cyl;
        end
        else if (load_en)
        begin
            cyl_reg <= load_cyl;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            served_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            served_reg <= 1'b0;
        end
        else if (mark_en)
        begin
            served_reg <= 1'b1;
        end
        else if (ctl.shift)
        begin
            served_reg <= from_next.served;
        end
    end

    assign value = '{cyl: cyl_reg, served: served_reg};

endmodule

// ===== hw/rtl/disk_seek_distance_top.sv =====
// Disk seek distance: total head travel under FCFS, SSTF or C-SCAN.
// Loading takes one transaction per cycle while idle. After the last request
// the stored requests are resolved: an init step, then for each further request
// a full rotation of the 64-cell request ring followed by an update step.
// Reset (async, active low) clears control, counters and served flags;
// policy resets to FCFS and top cylinder to 199.
module disk_seek_distance_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_idx,
    input  logic [15:0]          cfg_wdata,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  dsd_pkg::in_item_t    in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output dsd_pkg::out_item_t   out_data
);
    import dsd_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_INIT = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_STEP = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [1:0]        mode_reg;
    logic [CYL_W-1:0]  top_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [IDX_W-1:0]  s_reg, s_next;
    logic              dropped_reg, dropped_next;
    logic [CYL_W-1:0]  head_reg, head_next;
    logic [DIST_W-1:0] sum_reg, sum_next;
    logic              best_ok_reg, best_ok_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    logic [CYL_W-1:0]  best_c_reg, best_c_next;
    logic [CYL_W-1:0]  best_d_reg, best_d_next;
    logic              low_ok_reg, low_ok_next;
    logic [IDX_W-1:0]  low_idx_reg, low_idx_next;
    logic [CYL_W-1:0]  low_c_reg, low_c_next;
    logic              out_valid_reg;
    out_item_t         out_data_reg;

    cell_t             ring [MAX_REQ];
    logic [MAX_REQ-1:0] served_vec;
    cell_ctl_t         ctl;
    logic              mark_en;
    logic [IDX_W-1:0]  mark_idx;
    logic              accept, full, out_free;

    logic [CYL_W-1:0]  e_c, e_d;
    logic              e_live, e_cand;
    logic [STEP_W-1:0] step_d;
    logic [DIST_W:0]   sum_wide;

    assign accept   = in_valid && in_ready;
    assign full     = (count_reg >= CNT_W'(MAX_REQ));
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE);

    genvar gi;
    generate
        for (gi = 0; gi < MAX_REQ; gi++)
        begin : g_cell
            localparam int NXT = (gi + 1) % MAX_REQ;
            dsd_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .load_en   (accept && !full && (count_reg[IDX_W-1:0] == IDX_W'(gi))),
                .load_cyl  (in_data.request_cylinder),
                .mark_en   (mark_en && (mark_idx == IDX_W'(gi))),
                .from_next (ring[NXT]),
                .value     (ring[gi])
            );
            assign served_vec[gi] = ring[gi].served;
        end
    endgenerate

    // ring tail: at scan step s it holds request s
    always_comb
    begin
        e_c    = clamp(ring[0].cyl, top_reg);
        e_d    = gap(e_c, head_reg);
        e_live = ({1'b0, s_reg} < n_reg) && !ring[0].served;
        case (mode_reg)
            MODE_SSTF:  e_cand = e_live;
            MODE_CSCAN: e_cand = e_live && (e_c >= head_reg);
            default:    e_cand = ({1'b0, s_reg} == k_reg);
        endcase
    end

    // travel for one update step; the C-SCAN wrap folds three moves into one
    always_comb
    begin
        if (best_ok_reg)
        begin
            step_d = STEP_W'(gap(best_c_reg, head_reg));
        end
        else
        begin
            step_d = STEP_W'(top_reg - head_reg) + STEP_W'(top_reg)
                   + (low_ok_reg ? STEP_W'(low_c_reg) : STEP_W'(0));
        end
        sum_wide = {1'b0, sum_reg} + (DIST_W+1)'(step_d);
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        n_next        = n_reg;
        k_next        = k_reg;
        s_next        = s_reg;
        dropped_next  = dropped_reg;
        head_next     = head_reg;
        sum_next      = sum_reg;
        best_ok_next  = best_ok_reg;
        best_idx_next = best_idx_reg;
        best_c_next   = best_c_reg;
        best_d_next   = best_d_reg;
        low_ok_next   = low_ok_reg;
        low_idx_next  = low_idx_reg;
        low_c_next    = low_c_reg;
        ctl           = '{clear: 1'b0, shift: 1'b0};
        mark_en       = 1'b0;
        mark_idx      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    count_next   = full ? count_reg : count_reg + CNT_W'(1);
                    dropped_next = dropped_reg || full;
                    if (in_data.last_request)
                    begin
                        n_next     = count_next;
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT:
            begin
                head_next = clamp(ring[0].cyl, top_reg);
                sum_next  = '0;
                mark_en   = 1'b1;
                k_next    = CNT_W'(1);
                s_next    = '0;
                best_ok_next = 1'b0;
                low_ok_next  = 1'b0;
                state_next = (n_reg == CNT_W'(1)) ? ST_DONE : ST_SCAN;
            end
            ST_SCAN:
            begin
                ctl.shift = 1'b1;
                if (e_cand && (!best_ok_reg || (e_d < best_d_reg)))
                begin
                    best_ok_next  = 1'b1;
                    best_idx_next = s_reg;
                    best_c_next   = e_c;
                    best_d_next   = e_d;
                end
                if (e_live && (!low_ok_reg || (e_c < low_c_reg)))
                begin
                    low_ok_next  = 1'b1;
                    low_idx_next = s_reg;
                    low_c_next   = e_c;
                end
                s_next = s_reg + IDX_W'(1);
                if (s_reg == IDX_W'(MAX_REQ - 1))
                begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                best_ok_next = 1'b0;
                low_ok_next  = 1'b0;
                s_next       = '0;
                if (best_ok_reg || (mode_reg == MODE_CSCAN))
                begin
                    sum_next = (sum_wide > (DIST_W+1)'(DIST_MAX)) ? DIST_MAX
                                                                  : sum_wide[DIST_W-1:0];
                end
                if (best_ok_reg)
                begin
                    head_next = best_c_reg;
                    mark_en   = 1'b1;
                    mark_idx  = best_idx_reg;
                    k_next    = k_reg + CNT_W'(1);
                    state_next = (k_next == n_reg) ? ST_DONE : ST_SCAN;
                end
                else if ((mode_reg == MODE_CSCAN) && low_ok_reg)
                begin
                    head_next = low_c_reg;
                    mark_en   = 1'b1;
                    mark_idx  = low_idx_reg;
                    k_next    = k_reg + CNT_W'(1);
                    state_next = (k_next == n_reg) ? ST_DONE : ST_SCAN;
                end
                else
                begin
                    k_next     = n_reg;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    ctl.clear    = 1'b1;
                    count_next   = '0;
                    dropped_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= '0;
            top_reg       <= CYL_W'(199);
            count_reg     <= '0;
            n_reg         <= '0;
            k_reg         <= '0;
            s_reg         <= '0;
            dropped_reg   <= 1'b0;
            head_reg      <= '0;
            sum_reg       <= '0;
            best_ok_reg   <= 1'b0;
            low_ok_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            n_reg       <= n_next;
            k_reg       <= k_next;
            s_reg       <= s_next;
            dropped_reg <= dropped_next;
            head_reg    <= head_next;
            sum_reg     <= sum_next;
            best_ok_reg <= best_ok_next;
            low_ok_reg  <= low_ok_next;
            if (cfg_we)
            begin
                if (cfg_idx == REG_POLICY)
                begin
                    mode_reg <= cfg_wdata[1:0];
                end
                else if (cfg_idx == REG_TOP)
                begin
                    top_reg <= cfg_wdata;
                end
            end
            if ((state_reg == ST_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        best_idx_reg <= best_idx_next;
        best_c_reg   <= best_c_next;
        best_d_reg   <= best_d_next;
        low_idx_reg  <= low_idx_next;
        low_c_reg    <= low_c_next;
        if ((state_reg == ST_DONE) && out_free)
        begin
            out_data_reg <= '{total_distance: sum_reg, overflow_flag: dropped_reg};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ready)
        else $error("input ready while resolving a set");

    a_done_all_served: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> (k_reg == n_reg))
        else $error("set finished before all requests were served");

    a_served_count: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCAN) && (s_reg == '0)) |-> ($countones(served_vec) == k_reg))
        else $error("served flags disagree with served count");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_REQ))
        else $error("request count beyond capacity");

endmodule

// ===== tb/disk_seek_distance_top_test.sv =====
// Testbench for disk_seek_distance_top: loads request sets and checks the total seek travel.
// Depends on dsd_pkg and the top module; a local predictor computes every expected result.
`timescale 1ns / 100ps

module disk_seek_distance_top_test;

    import dsd_pkg::*;

    localparam int CYCLE_CAP  = 3000000;
    localparam int RAND_ITEMS = 1100;

    localparam logic [1:0] MODE_FCFS = 2'd0;
    localparam logic [1:0] MODE_ODD  = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_idx;
    logic [15:0] cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_data;

    disk_seek_distance_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // predictor state
    logic [1:0]        cur_mode;
    logic [15:0]       cur_top;
    logic [15:0]       set_cyl [MAX_REQ];
    int                set_len;
    logic              set_dropped;
    out_item_t         pending_totals [$];

    int  err_count;
    int  cycle_count;
    int  sets_done;
    int  items_sent;
    bit  quiet_mode;
    int  send_gap;

    function automatic logic [15:0] clip_cyl(input logic [15:0] c);
        return (c > cur_top) ? cur_top : c;
    endfunction

    function automatic logic [21:0] add_sat(input logic [21:0] s, input logic [31:0] d);
        logic [31:0] t;
        t = 32'(s) + d;
        return (t > 32'(DIST_MAX)) ? DIST_MAX : t[21:0];
    endfunction

    function automatic logic [21:0] seek_total();
        logic [21:0] sum;
        logic [15:0] head;
        logic [15:0] c;
        bit          done [MAX_REQ];
        int          nx;
        int          bd;
        int          d;
        sum = '0;
        if (set_len == 0)
            return sum;
        foreach (done[k])
            done[k] = 0;
        done[0] = 1;
        head = clip_cyl(set_cyl[0]);
        for (int step = 1; step < set_len; step++)
        begin
            nx = -1;
            if (cur_mode == MODE_SSTF || cur_mode == MODE_CSCAN)
            begin
                bd = 0;
                for (int k = 0; k < set_len; k++)
                begin
                    c = clip_cyl(set_cyl[k]);
                    if (done[k] || (cur_mode == MODE_CSCAN && c < head))
                        continue;
                    d = (c > head) ? c - head : head - c;
                    if (nx < 0 || d < bd)
                    begin
                        nx = k;
                        bd = d;
                    end
                end
                if (nx < 0)
                begin
                    // wrap: run to top, sweep back to 0, take the lowest left
                    sum = add_sat(sum, 32'(cur_top - head));
                    sum = add_sat(sum, 32'(cur_top));
                    for (int k = 0; k < set_len; k++)
                        if (!done[k] && (nx < 0
                            || clip_cyl(set_cyl[k]) < clip_cyl(set_cyl[nx])))
                            nx = k;
                    if (nx < 0)
                        return sum;
                    head = '0;
                end
            end
            else
                nx = step;
            c = clip_cyl(set_cyl[nx]);
            sum = add_sat(sum, 32'((c > head) ? c - head : head - c));
            head = c;
            done[nx] = 1;
        end
        return sum;
    endfunction

    task automatic absorb_request(input in_item_t it);
        out_item_t r;
        if (set_len < MAX_REQ)
        begin
            set_cyl[set_len] = it.request_cylinder;
            set_len++;
        end
        else
            set_dropped = 1'b1;
        if (it.last_request)
        begin
            r.total_distance = seek_total();
            r.overflow_flag  = set_dropped;
            pending_totals.push_back(r);
            set_len     = 0;
            set_dropped = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        err_count++;
    endtask

    // output side: check each transaction against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_totals.size() == 0)
                report_mismatch("unexpected result, distance", out_data.total_distance, 0);
            else
            begin
                out_item_t w;
                w = pending_totals.pop_front();
                if (out_data.total_distance !== w.total_distance)
                    report_mismatch("total_distance", out_data.total_distance,
                                    w.total_distance);
                if (out_data.overflow_flag !== w.overflow_flag)
                    report_mismatch("overflow_flag", out_data.overflow_flag, w.overflow_flag);
                sets_done++;
            end
        end
    end

    // receiver stalls in bursts
    int stall_left;
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b1;
            stall_left = 0;
        end
        else if (quiet_mode)
            out_ready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= (stall_left == 0);
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(1, 16);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_POLICY)
            cur_mode = val[1:0];
        else
            cur_top = val;
    endtask

    // valid stays high after a transaction until a gap or a drain drops it
    task automatic send_request(input logic [15:0] cyl, input logic last);
        in_item_t it;
        it.request_cylinder = cyl;
        it.last_request     = last;
        if (!quiet_mode && send_gap == 0 && $urandom_range(0, 7) == 0)
            send_gap = $urandom_range(1, 16);
        if (send_gap > 0)
            in_valid <= 1'b0;
        while (send_gap > 0)
        begin
            @(posedge clk);
            send_gap--;
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        absorb_request(it);
        items_sent++;
    endtask

    // wait until all results are back, then let any in-flight work settle
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_totals.size() != 0)
            @(posedge clk);
        repeat (4200)
            @(posedge clk);
    endtask

    task automatic random_set(input int len, input int wide);
        logic [15:0] c;
        for (int k = 0; k < len; k++)
        begin
            case ($urandom_range(0, 3))
                0: c = 16'($urandom_range(0, 65535));
                1: c = 16'($urandom_range(0, wide));
                2: c = (k == 0) ? 16'($urandom_range(0, 65535))
                                : set_cyl[$urandom_range(0, set_len > 0 ? set_len - 1 : 0)];
                default: c = cur_top;
            endcase
            send_request(c, k == len - 1);
        end
    endtask

    // directed table: cylinder, last flag, expected total (-1: use predictor)
    typedef struct {
        logic [15:0] cyl;
        logic        last;
        int          want;
    } dir_row_t;

    dir_row_t dir_rows [] = '{
        '{16'd0,     1'b1, 0},
        '{16'd65535, 1'b1, 0},
        '{16'd50,    1'b0, -1},
        '{16'd10,    1'b0, -1},
        '{16'd199,   1'b1, 229},
        '{16'd0,     1'b0, -1},
        '{16'd65535, 1'b1, 199},
        '{16'd100,   1'b0, -1},
        '{16'd120,   1'b0, -1},
        '{16'd80,    1'b0, -1},
        '{16'd150,   1'b1, -1}
    };

    int          n;

    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_idx     = REG_POLICY;
        cfg_wdata   = '0;
        in_valid    = 1'b0;
        in_data     = '0;
        cur_mode    = MODE_FCFS;
        cur_top     = 16'd199;
        set_len     = 0;
        set_dropped = 1'b0;
        err_count   = 0;
        cycle_count = 0;
        sets_done   = 0;
        items_sent  = 0;
        quiet_mode  = 0;
        send_gap    = 0;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows under reset config, then SSTF and C-SCAN over the same table
        for (int m = 0; m < 3; m++)
        begin
            if (m > 0)
            begin
                drain();
                write_reg(REG_POLICY, (m == 1) ? 16'(MODE_SSTF) : 16'(MODE_CSCAN));
            end
            foreach (dir_rows[i])
            begin
                send_request(dir_rows[i].cyl, dir_rows[i].last);
                if (m == 0 && dir_rows[i].last && dir_rows[i].want >= 0
                    && pending_totals[$].total_distance != 22'(dir_rows[i].want))
                    report_mismatch("directed row", pending_totals[$].total_distance,
                                    dir_rows[i].want);
            end
        end

        // store overflow: 70 requests, the last six dropped
        drain();
        write_reg(REG_POLICY, 16'(MODE_ODD));
        for (int k = 0; k < 70; k++)
            send_request(16'($urandom_range(0, 65535)), k == 69);
        drain();
        write_reg(REG_TOP, 16'd0);
        write_reg(REG_POLICY, 16'(MODE_CSCAN));
        random_set(5, 65535);
        drain();
        write_reg(REG_TOP, 16'd65535);
        for (int k = 0; k < 64; k++)
            send_request((k % 2) ? 16'd65535 : 16'd0, k == 63);

        // random phases with config sweeps
        while (items_sent < RAND_ITEMS)
        begin
            drain();
            write_reg(REG_POLICY, 16'($urandom_range(0, 3)));
            case ($urandom_range(0, 3))
                0: write_reg(REG_TOP, 16'd1);
                1: write_reg(REG_TOP, 16'd65535);
                default: write_reg(REG_TOP, 16'($urandom_range(1, 65535)));
            endcase
            if (items_sent > RAND_ITEMS * 3 / 4)
                quiet_mode = 1;
            repeat ($urandom_range(3, 8))
            begin
                n = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 68)
                                                 : $urandom_range(1, 12);
                random_set(n, $urandom_range(0, 1) ? 300 : 65535);
            end
        end

        drain();
        $display("covered %0d requests in %0d sets across all policies and top settings",
                 items_sent, sets_done);
        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
